// ===== src/mbaeg_pkg.sv =====
`timescale 1ns / 1ps
package mbaeg_pkg;

  localparam int PAT_MAX     = 64;
  localparam int PATTERN_BITS_DEF = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic       ACT_CHECK     = 1'b0;
  localparam logic       ACT_CLEAR     = 1'b1;
  localparam logic [1:0] CFG_IDX_MASK  = 2'd0;
  localparam logic [1:0] CFG_IDX_TRIG  = 2'd1;

  typedef struct packed {
    logic        action;
    logic [63:0] pattern_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  bit_position;
    logic        raised;
    logic [63:0] reported_value;
    logic [6:0]  active_count;
    logic        last_event;
  } out_item_t;

  // Work handed from classifier to event engine
  typedef struct packed {
    logic [PAT_MAX-1:0] hits;
    logic [PAT_MAX-1:0] ups;
    logic [PAT_MAX-1:0] value;
  } job_t;

endpackage

// ===== src/mbaeg_front.sv =====
`timescale 1ns / 1ps
module mbaeg_front #(
  parameter int PATTERN_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbaeg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mbaeg_pkg::in_item_t            in_data,
  output logic                           push,
  output mbaeg_pkg::job_t                push_job,
  input  logic                           q_full
);
  import mbaeg_pkg::*;

  localparam int N = PATTERN_BITS;

  logic [N-1:0] mask_r, trig_r, prev_r;
  logic [N-1:0] mask_nxt, trig_nxt, prev_nxt;
  logic         seen_r, seen_nxt;
  logic [N-1:0] old_pat, value, hits;
  logic         accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign old_pat  = seen_r ? prev_r : ~trig_r;

  always_comb begin
    mask_nxt = mask_r;
    trig_nxt = trig_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_MASK: mask_nxt = cfg_wdata[N-1:0];
        CFG_IDX_TRIG: trig_nxt = cfg_wdata[N-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prev_nxt = prev_r;
    seen_nxt = seen_r;
    push     = 1'b0;
    value    = old_pat;
    hits     = '0;
    push_job = '0;
    if (in_data.action == ACT_CHECK) begin
      value = in_data.pattern_value[N-1:0];
      hits  = mask_r & (value ^ old_pat);
      push_job.ups = PAT_MAX'(~(value ^ trig_r));
    end else begin
      hits = mask_r & ~(trig_r ^ old_pat);
    end
    push_job.hits  = PAT_MAX'(hits);
    push_job.value = PAT_MAX'(value);
    if (accept) begin
      seen_nxt = 1'b1;
      push     = (hits != '0);
      // an unchanged pattern gives no hits and stores the same value
      if (in_data.action == ACT_CHECK) begin
        prev_nxt = value;
      end else begin
        prev_nxt = (~mask_r & old_pat) | (mask_r & ~trig_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      trig_r <= '0;
      prev_r <= '0;
      seen_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      trig_r <= trig_nxt;
      prev_r <= prev_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ===== src/mbaeg_queue.sv =====
`timescale 1ns / 1ps
module mbaeg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbaeg_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output mbaeg_pkg::job_t q_job
);
  import mbaeg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_job   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/mbaeg_back.sv =====
`timescale 1ns / 1ps
module mbaeg_back #(
  parameter int PATTERN_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  mbaeg_pkg::job_t      q_job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mbaeg_pkg::out_item_t out_data
);
  import mbaeg_pkg::*;

  localparam int N     = PATTERN_BITS;
  localparam int POS_W = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0]      sh_r, sh_nxt, ups_r, ups_nxt;
  logic [63:0]       value_r, value_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         od_r, od_nxt;
  logic              busy, slot_free, step, emit;

  assign busy      = (sh_r != '0);
  assign slot_free = !ov_r || out_ready;
  assign emit      = busy && sh_r[0] && slot_free;
  // non-hit bits are skipped whatever the output side does
  assign step      = busy && (!sh_r[0] || slot_free);
  assign pop       = !busy && q_valid;

  always_comb begin
    sh_nxt    = sh_r;
    ups_nxt   = ups_r;
    value_nxt = value_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (pop) begin
      sh_nxt    = q_job.hits[N-1:0];
      ups_nxt   = q_job.ups[N-1:0];
      value_nxt = q_job.value;
      pos_nxt   = '0;
    end else if (step) begin
      sh_nxt  = sh_r >> 1;
      ups_nxt = ups_r >> 1;
      pos_nxt = pos_r + 1'b1;
    end
    if (emit) begin
      if (ups_r[0]) begin
        cnt_nxt = (cnt_r < 7'd64) ? cnt_r + 7'd1 : cnt_r;
      end else begin
        cnt_nxt = (cnt_r > 7'd0) ? cnt_r - 7'd1 : cnt_r;
      end
      ov_nxt                = 1'b1;
      od_nxt.bit_position   = 6'(pos_r);
      od_nxt.raised         = ups_r[0];
      od_nxt.reported_value = value_r;
      od_nxt.active_count   = cnt_nxt;
      od_nxt.last_event     = ((sh_r >> 1) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r  <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      sh_r  <= sh_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ups_r   <= ups_nxt;
    value_r <= value_nxt;
    pos_r   <= pos_nxt;
    od_r    <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== src/masked_bit_alarm_event_generator.sv =====
`timescale 1ns / 1ps
// Masked bit alarm event generator.
// Input channel (in_valid/in_ready/in_data): one request per check or clear.
// A check request carries a new status pattern; a clear request clears all
// alarms currently active. Output channel (out_valid/out_ready/out_data):
// one event per masked bit concerned, rising bit order, last_event flagged.
// Config port (cfg_we/cfg_index/cfg_wdata): index 0 alarm mask, 1 trigger.
// Flow: a request is classified on acceptance and queued; the event engine
// takes it from the queue once idle and walks the hit bits one per cycle while
// the receiver keeps up. Each event leaves a registered output in the cycle
// after its bit is reached. Requests causing no event only touch state.
// The two-entry queue lets new requests be accepted while events drain.
// Reset (synchronous, rst_n low) clears the registers, the stored pattern,
// the alarm count, the queue and the output valid.
// If the receiver stalls, the pending event holds and the engine stops at the
// next hit bit; once the queue fills, in_ready drops.
module masked_bit_alarm_event_generator #(
  parameter int PATTERN_BITS = mbaeg_pkg::PATTERN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbaeg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mbaeg_pkg::in_item_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mbaeg_pkg::out_item_t           out_data
);
  import mbaeg_pkg::*;

  // classifier -> queue
  logic push, q_full;
  job_t push_job;
  // queue -> event engine
  logic q_valid, pop;
  job_t q_job;

  // front: register file, stored pattern, hit and polarity vectors
  mbaeg_front #(.PATTERN_BITS(PATTERN_BITS)) u_front (
    .clk, .rst_n,
    .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_data,
    .push, .push_job, .q_full
  );

  mbaeg_queue u_queue (
    .clk, .rst_n,
    .push, .push_job, .full(q_full),
    .pop, .q_valid, .q_job
  );

  // back: bit walker, alarm count, output register
  mbaeg_back #(.PATTERN_BITS(PATTERN_BITS)) u_back (
    .clk, .rst_n,
    .q_valid, .q_job, .pop,
    .out_valid, .out_ready, .out_data
  );

endmodule
